// ----- design/sigmoid_perceptron_trainer_macros.svh -----
// Assertion macros shared by the checker of sigmoid_perceptron_trainer.
// Depends on a clk and an active-low arst_n in the scope of use.
`ifndef SIGMOID_PERCEPTRON_TRAINER_MACROS_SVH
`define SIGMOID_PERCEPTRON_TRAINER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/spt_pkg.sv -----
// Package of sigmoid_perceptron_trainer: codes, command/status structs,
// fixed widths and the elaboration-time sigmoid table builder. No dependencies.
package spt_pkg;

	localparam int NUM_FEATURES_DEF    = 3;
	localparam int SIGMOID_ENTRIES_DEF = 256;
	localparam int FEATURE_FIELDS      = 3;

	localparam int DATA_W = 16;
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;
	localparam int FRAC_SHIFT = 16;
	// sum is Q8.24, table step is 16/ENTRIES: index = (sum + 8) * ENTRIES >> 28
	localparam int IDX_SHIFT = 28;
	localparam longint SUM_BIAS = 64'd8 << 24;

	typedef enum logic [1:0] {
		KIND_TRAIN   = 2'd0,
		KIND_PREDICT = 2'd1,
		KIND_LOAD    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MUL_DOT,
		MUL_DERIV,
		MUL_ERR,
		MUL_UPD
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_DOT_END,
		ST_INDEX,
		ST_LOOK,
		ST_DERIV,
		ST_ERR,
		ST_ADJ,
		ST_UPD,
		ST_UPD_END,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     idx_en;
		logic     pred_en;
		logic     adj_en;
		logic     w_wr;
		logic     w_load;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic train;
		logic load;
	} dp_status_t;

	// Restoring division, used only while building constants.
	function automatic logic [63:0] udiv_const(logic [63:0] a, logic [63:0] b);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], a[i]};
			if (rem >= b) begin
				rem = rem - b;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sigmoid table entry k in Q0.16 for x = -8 + k*16/entries.
	function automatic logic [15:0] sig_entry(int unsigned k, int unsigned entries);
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] val;
		longint      acc;
		int unsigned half;
		int unsigned steps;
		y    = udiv_const(64'd16 << 30, 64'(entries));
		term = 64'd1 << 30;
		acc  = longint'(64'd1 << 30);
		for (int n = 1; n <= 24; n++) begin
			term = udiv_const((term * y) >> 30, 64'(n));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		r     = (acc > 0) ? 64'(acc) : 64'd0;
		half  = entries >> 1;
		steps = (k >= half) ? (k - half) : (half - k);
		p     = 64'd1 << 30;
		for (int j = 0; j < int'(steps); j++) begin
			p = (p * r + (64'd1 << 29)) >> 30;
		end
		den = (64'd1 << 30) + p;
		if (k >= half) begin
			val = udiv_const((64'd1 << 46) + (den >> 1), den);
		end else begin
			val = udiv_const((p << 16) + (den >> 1), den);
		end
		return (val > 64'd65535) ? 16'hFFFF : val[15:0];
	endfunction

endpackage

// ----- design/spt_req_if.sv -----
// Request channel of sigmoid_perceptron_trainer: valid/ready plus payload.
// Standalone; no package dependency.
interface spt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] feature_0;
	logic signed [15:0] feature_1;
	logic signed [15:0] feature_2;
	logic [15:0]        target;

	modport source (
		output valid, kind, feature_0, feature_1, feature_2, target,
		input  ready
	);
	modport sink (
		input  valid, kind, feature_0, feature_1, feature_2, target,
		output ready
	);
endinterface

// ----- design/spt_res_if.sv -----
// Result channel of sigmoid_perceptron_trainer: valid/ready plus payload.
// Standalone; no package dependency.
interface spt_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] prediction;
	logic        saturated;

	modport source (
		output valid, prediction, saturated,
		input  ready
	);
	modport sink (
		input  valid, prediction, saturated,
		output ready
	);
endinterface

// ----- design/spt_ctrl.sv -----
// Sequencer of sigmoid_perceptron_trainer: steps the shared multiplier.
// Depends on spt_pkg.
module spt_ctrl import spt_pkg::*; #(
	parameter int NUM_FEATURES = NUM_FEATURES_DEF,
	localparam int CNT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dp_status_t       status,
	output dp_cmd_t          cmd,
	output logic [CNT_W-1:0] rd_idx
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_FEATURES - 1);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             cnt_last;
	logic             counting;

	assign cnt_last  = (cnt_q == LAST);
	assign counting  = (state_q == ST_DOT) || (state_q == ST_UPD);
	assign rd_idx    = cnt_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (counting && !cnt_last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_DOT;
			ST_DOT:     if (cnt_last) state_d = ST_DOT_END;
			ST_DOT_END: state_d = ST_INDEX;
			ST_INDEX:   state_d = ST_LOOK;
			ST_LOOK:    state_d = status.train ? ST_DERIV : ST_DONE;
			ST_DERIV:   state_d = ST_ERR;
			ST_ERR:     state_d = ST_ADJ;
			ST_ADJ:     state_d = ST_UPD;
			ST_UPD:     if (cnt_last) state_d = ST_UPD_END;
			ST_UPD_END: state_d = ST_DONE;
			ST_DONE:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = MUL_DOT;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DOT: begin
				cmd.mul_sel = MUL_DOT;
				cmd.acc_en  = (cnt_q != '0);
			end
			ST_DOT_END: cmd.acc_en = 1'b1;
			ST_INDEX:   cmd.idx_en = 1'b1;
			ST_LOOK: begin
				cmd.pred_en = 1'b1;
				cmd.w_load  = status.load;
			end
			ST_DERIV: cmd.mul_sel = MUL_DERIV;
			ST_ERR:   cmd.mul_sel = MUL_ERR;
			ST_ADJ:   cmd.adj_en  = 1'b1;
			ST_UPD: begin
				cmd.mul_sel = MUL_UPD;
				cmd.w_wr    = (cnt_q != '0);
			end
			ST_UPD_END: cmd.w_wr = 1'b1;
			ST_DONE:    cmd.out_load = !out_valid_q || out_ready;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- design/spt_datapath.sv -----
// Datapath of sigmoid_perceptron_trainer: weights, shared 18x18 multiplier,
// accumulator, sigmoid table and result registers. Depends on spt_pkg.
module spt_datapath import spt_pkg::*; #(
	parameter int NUM_FEATURES    = NUM_FEATURES_DEF,
	parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF,
	localparam int CNT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  logic [CNT_W-1:0]         rd_idx,
	output dp_status_t               status,
	input  logic [1:0]               kind,
	input  logic signed [DATA_W-1:0] feature_0,
	input  logic signed [DATA_W-1:0] feature_1,
	input  logic signed [DATA_W-1:0] feature_2,
	input  logic [DATA_W-1:0]        target,
	output logic [DATA_W-1:0]        prediction,
	output logic                     saturated
);

	localparam int SUM_W = 33 + $clog2(NUM_FEATURES);
	localparam int EW    = $clog2(SIGMOID_ENTRIES + 1);
	localparam int SC_W  = SUM_W + EW;
	localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam logic signed [MUL_W-1:0] W_MAX = MUL_W'(32767);
	localparam logic signed [MUL_W-1:0] W_MIN = -MUL_W'(32768);

	logic signed [DATA_W-1:0] weight_q [NUM_FEATURES];
	logic signed [DATA_W-1:0] feat_q   [NUM_FEATURES];
	logic signed [DATA_W-1:0] feat_in  [NUM_FEATURES];
	logic [1:0]               kind_q;
	logic [DATA_W-1:0]        target_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] w_s1;
	logic [CNT_W-1:0]         idx_s1;

	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W:0]    biased;
	logic [SC_W-1:0]          scaled;
	logic [SC_W-1:0]          scaled_sh;
	logic [IDX_W-1:0]         idx_d, idx_q;
	logic [DATA_W-1:0]        sig_rom [SIGMOID_ENTRIES];
	logic [DATA_W-1:0]        pred_q;
	logic [DATA_W:0]          one_minus;
	logic signed [MUL_W-1:0]  adj_q;
	logic signed [MUL_W-1:0]  delta;
	logic signed [MUL_W-1:0]  w_sum;
	logic signed [DATA_W-1:0] w_new;
	logic                     w_clip;
	logic                     sat_q;
	logic [DATA_W-1:0]        pred_out_q;
	logic                     sat_out_q;

	// Features beyond the three request fields read as zero.
	for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_feat
		if (i == 0) begin : g_f0
			assign feat_in[i] = feature_0;
		end else if (i == 1) begin : g_f1
			assign feat_in[i] = feature_1;
		end else if (i == 2) begin : g_f2
			assign feat_in[i] = feature_2;
		end else begin : g_fz
			assign feat_in[i] = '0;
		end
	end

	for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
		assign sig_rom[k] = sig_entry(k, SIGMOID_ENTRIES);
	end

	assign status.train = (kind_q == KIND_TRAIN);
	assign status.load  = (kind_q == KIND_LOAD);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			target_q <= target;
			for (int i = 0; i < NUM_FEATURES; i++) begin
				feat_q[i] <= feat_in[i];
			end
		end
	end

	// Shared multiplier operand select.
	assign one_minus = 17'h10000 - {1'b0, pred_q};
	always_comb begin
		case (cmd.mul_sel)
			MUL_DOT: begin
				mul_a = MUL_W'(weight_q[rd_idx]);
				mul_b = MUL_W'(feat_q[rd_idx]);
			end
			MUL_DERIV: begin
				mul_a = {2'b00, pred_q};
				mul_b = {1'b0, one_minus};
			end
			MUL_ERR: begin
				mul_a = {2'b00, target_q} - {2'b00, pred_q};
				mul_b = {2'b00, prod_q[31:16]};
			end
			MUL_UPD: begin
				mul_a = MUL_W'(feat_q[rd_idx]);
				mul_b = adj_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		w_s1   <= weight_q[rd_idx];
		idx_s1 <= rd_idx;
	end

	// Dot product accumulation and table index.
	assign biased    = {acc_q[SUM_W-1], acc_q} + (SUM_W+1)'(SUM_BIAS);
	assign scaled    = SC_W'(biased[SUM_W-1:0]) * SC_W'(SIGMOID_ENTRIES);
	assign scaled_sh = scaled >> IDX_SHIFT;
	always_comb begin
		if (biased[SUM_W]) begin
			idx_d = '0;
		end else if (scaled_sh > SC_W'(SIGMOID_ENTRIES - 1)) begin
			idx_d = IDX_W'(SIGMOID_ENTRIES - 1);
		end else begin
			idx_d = scaled_sh[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + prod_q[SUM_W-1:0];
		end
		if (cmd.idx_en) begin
			idx_q <= idx_d;
		end
		if (cmd.pred_en) begin
			pred_q <= sig_rom[idx_q];
		end
		if (cmd.adj_en) begin
			adj_q <= prod_q[MUL_W+FRAC_SHIFT-1:FRAC_SHIFT];
		end
	end

	// Weight update with clamp.
	assign delta = prod_q[MUL_W+FRAC_SHIFT-1:FRAC_SHIFT];
	assign w_sum = MUL_W'(w_s1) + delta;
	always_comb begin
		w_clip = 1'b0;
		w_new  = w_sum[DATA_W-1:0];
		if (w_sum > W_MAX) begin
			w_new  = 16'sh7FFF;
			w_clip = 1'b1;
		end else if (w_sum < W_MIN) begin
			w_new  = 16'sh8000;
			w_clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FEATURES; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cmd.w_load) begin
			for (int i = 0; i < NUM_FEATURES; i++) begin
				weight_q[i] <= feat_q[i];
			end
		end else if (cmd.w_wr) begin
			weight_q[idx_s1] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sat_q <= 1'b0;
		end else if (cmd.w_wr && w_clip) begin
			sat_q <= 1'b1;
		end
		if (cmd.out_load) begin
			pred_out_q <= pred_q;
			sat_out_q  <= sat_q;
		end
	end

	assign prediction = pred_out_q;
	assign saturated  = sat_out_q;

endmodule

// ----- design/sigmoid_perceptron_trainer.sv -----
// Sigmoid perceptron trainer (single neuron, delta rule, fixed point).
//
// Channels: request (kind, feature_0..2, target) and result (prediction,
// saturated), both valid/ready; a transfer happens on a rising edge with
// valid and ready high. Every request yields exactly one result.
// kind 0 trains, kind 1 (and the unused code 3) predicts, kind 2 loads the
// weights from the features. prediction is the sigmoid of the dot product
// with the weights held before the request.
// A train request passes the dot product, table index and lookup steps, then
// the derivative, error, adjustment and weight update steps before its result;
// predict and load requests end after the lookup. The next request is taken
// once the sequencer has loaded the result register and is back in idle.
// One request is worked on at a time; the single shared 18x18 multiplier
// forms the dot product terms, the derivative, the adjustment and each
// weight delta.
// The result sits in an output register: a new request is taken while the
// previous result still waits, and a stalled receiver only holds the
// sequencer at its final step until the register frees up.
// Reset (arst_n low) clears the weights to zero and drops any result.
// Depends on spt_pkg, spt_req_if, spt_res_if, spt_ctrl, spt_datapath.
module sigmoid_perceptron_trainer import spt_pkg::*; #(
	parameter int NUM_FEATURES    = NUM_FEATURES_DEF,
	parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	spt_req_if.sink  request,
	spt_res_if.source result
);

	localparam int CNT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [CNT_W-1:0] rd_idx;

	// Sequencer: owns handshakes and steps the datapath.
	spt_ctrl #(
		.NUM_FEATURES (NUM_FEATURES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd),
		.rd_idx    (rd_idx)
	);

	// Datapath: weights, multiplier, table and result payload.
	spt_datapath #(
		.NUM_FEATURES    (NUM_FEATURES),
		.SIGMOID_ENTRIES (SIGMOID_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_idx     (rd_idx),
		.status     (status),
		.kind       (request.kind),
		.feature_0  (request.feature_0),
		.feature_1  (request.feature_1),
		.feature_2  (request.feature_2),
		.target     (request.target),
		.prediction (result.prediction),
		.saturated  (result.saturated)
	);

endmodule

// ----- design/spt_checker.sv -----
// Port-level checks of sigmoid_perceptron_trainer, bound to the top level.
// Depends on sigmoid_perceptron_trainer_macros.svh.
`include "sigmoid_perceptron_trainer_macros.svh"

module spt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_prediction,
	input logic        res_saturated
);

	logic [1:0] pending_q;
	logic       req_fire;
	logic       res_fire;

	assign req_fire = req_valid && req_ready;
	assign res_fire = res_valid && res_ready;

	// Track requests taken but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_fire && !res_fire) begin
			pending_q <= pending_q + 2'd1;
		end else if (res_fire && !req_fire) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`SPT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_prediction) && $stable(res_saturated), "result changed while stalled")
	`SPT_ASSERT_NXT(a_one_at_a_time, req_fire, !req_ready, "request taken while busy")
	`SPT_ASSERT_IMP(a_no_orphan, res_valid, pending_q != 2'd0, "result without request")
	`SPT_ASSERT_IMP(a_depth, req_ready, pending_q < 2'd2, "too many requests in flight")

endmodule

bind sigmoid_perceptron_trainer spt_checker u_spt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (request.valid),
	.req_ready      (request.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_prediction (result.prediction),
	.res_saturated  (result.saturated)
);
